>>> design/life_like_automaton_row_step_macros.svh
// ----------------------------------------------------------------------------
// Life-like automaton row step: assertion macros
// Shared concurrent assertion forms for the row step block.
// ----------------------------------------------------------------------------
`ifndef LIFE_LIKE_AUTOMATON_ROW_STEP_MACROS_SVH
`define LIFE_LIKE_AUTOMATON_ROW_STEP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LLARS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LLARS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/llars_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Life-like automaton row step: package
// Word types, status group and rule constants shared by the row step modules.
// ----------------------------------------------------------------------------
package llars_pkg;

   // Fixed field widths.
   localparam int CELLS_WIDTH = 64;
   localparam int LEN_WIDTH   = 7;

   // Reset value of the row length register.
   localparam logic [LEN_WIDTH-1:0] ROW_LENGTH_RESET = 7'd64;

   // Neighbor count and the B678/S2345 rule thresholds.
   typedef logic [3:0] count_type;
   localparam count_type SURVIVE_ABOVE = 4'd1;
   localparam count_type SURVIVE_BELOW = 4'd6;
   localparam count_type BIRTH_ABOVE   = 4'd5;

   // Number of grid rows currently held.
   typedef logic [1:0] held_type;
   localparam held_type HELD_NONE = 2'd0;
   localparam held_type HELD_ONE  = 2'd1;
   localparam held_type HELD_TWO  = 2'd2;

   // Input word: one grid row.
   typedef struct packed {
      logic [CELLS_WIDTH-1:0] row_cells;
      logic                   last_row;
   } req_word_type;

   // Output word: one next-generation row.
   typedef struct packed {
      logic [CELLS_WIDTH-1:0] next_cells;
      logic                   final_row;
   } rsp_word_type;

   // Status of the result buffer.
   typedef struct packed {
      logic has_space;
      logic not_empty;
   } fifo_status_type;

endpackage
`default_nettype wire

>>> design/llars_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Life-like automaton row step: cell lane
// Counts the eight neighbors of one cell and applies the B678/S2345 rule.
// ----------------------------------------------------------------------------
module llars_cell (
   input  wire logic [7:0] neighbors,
   input  wire logic       alive,
   output logic            next_alive
);

   llars_pkg::count_type count;

   // Add up the live neighbors.
   always_comb begin
      count = '0;
      for (int k = 0; k < 8; k++) begin
         count = count + llars_pkg::count_type'(neighbors[k]);
      end
   end

   // A live cell survives with two to five neighbors; a dead one is born with six or more.
   always_comb begin
      if (alive) begin
         next_alive = (count > llars_pkg::SURVIVE_ABOVE) && (count < llars_pkg::SURVIVE_BELOW);
      end else begin
         next_alive = count > llars_pkg::BIRTH_ABOVE;
      end
   end

endmodule
`default_nettype wire

>>> design/llars_lanes.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Life-like automaton row step: lane array
// One cell lane per column works on a three-row window; the merge masks the
// lane outputs to the used row length and gathers them into one row.
// ----------------------------------------------------------------------------
module llars_lanes #(
   parameter int ROW_CELLS = 64
) (
   input  wire logic [ROW_CELLS-1:0] upper,
   input  wire logic [ROW_CELLS-1:0] middle,
   input  wire logic [ROW_CELLS-1:0] lower,
   input  wire logic [ROW_CELLS-1:0] used_mask,
   output logic      [ROW_CELLS-1:0] next_row
);

   logic [ROW_CELLS+1:0] up_pad;
   logic [ROW_CELLS+1:0] mid_pad;
   logic [ROW_CELLS+1:0] low_pad;
   logic [ROW_CELLS-1:0] lane_out;

   // Cells beyond the used length and outside the grid edges count as dead.
   assign up_pad  = {1'b0, upper  & used_mask, 1'b0};
   assign mid_pad = {1'b0, middle & used_mask, 1'b0};
   assign low_pad = {1'b0, lower  & used_mask, 1'b0};

   // One lane per column.
   for (genvar j = 0; j < ROW_CELLS; j++) begin : g_lane
      llars_cell u_cell (
         .neighbors  ({up_pad[j+2:j], low_pad[j+2:j], mid_pad[j], mid_pad[j+2]}),
         .alive      (mid_pad[j+1]),
         .next_alive (lane_out[j])
      );
   end

   // Merge the lanes into the output row, cleared beyond the used length.
   assign next_row = lane_out & used_mask;

endmodule
`default_nettype wire

>>> design/llars_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Life-like automaton row step: result buffer
// Two-entry buffer between the lane array and the result channel.
// ----------------------------------------------------------------------------
module llars_fifo (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire llars_pkg::rsp_word_type  push_word,
   input  wire logic                     pop,
   output llars_pkg::rsp_word_type       head_word,
   output llars_pkg::fifo_status_type    status
);

   llars_pkg::rsp_word_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff,  count_in;
   logic       do_pop;

   assign do_pop           = pop && (count_ff != 2'd0);
   assign status.not_empty = count_ff != 2'd0;
   assign status.has_space = count_ff != 2'd2;
   assign head_word        = slot_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + 2'(push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage of the buffered words.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule
`default_nettype wire

>>> design/life_like_automaton_row_step.sv
`timescale 1ns / 1ps
`default_nettype none
`include "life_like_automaton_row_step_macros.svh"
// ----------------------------------------------------------------------------
// Life-like automaton row step (rule B678/S2345, no wrap-around)
//
// Rows of a grid enter on the req_ channel, one 64-bit word per row, with
// last_row set on the final row. Results leave on the rsp_ channel, both
// channels valid/ready. The next-generation row for row i leaves when row
// i+1 is accepted; the last row adds one more word marked final_row.
// A word enters the output buffer when the row that completes it is
// accepted. Throughput: one row per cycle while req_ready is high; after a
// row with last_row, a flush step computes the final word. The user must
// write row_length (cells used per row) via csr_wr_en only while the block
// is idle; the block does not enforce it. Reset sets row_length to 64 and
// clears the held rows and the buffer. A two-word buffer parts the sides;
// when the receiver stalls it fills and req_ready drops until a word is taken.
// ----------------------------------------------------------------------------
module life_like_automaton_row_step #(
   parameter int ROW_CELLS = 64
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire llars_pkg::req_word_type              req_word,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output llars_pkg::rsp_word_type                   rsp_word,
   input  wire logic                                 csr_wr_en,
   input  wire logic [llars_pkg::LEN_WIDTH-1:0]      csr_wr_data
);

   logic [llars_pkg::LEN_WIDTH-1:0] row_length_ff;
   logic [ROW_CELLS-1:0]            upper_ff,  upper_in;
   logic [ROW_CELLS-1:0]            middle_ff, middle_in;
   llars_pkg::held_type             held_ff,   held_in;
   logic                            flush_ff,  flush_in;

   logic [ROW_CELLS-1:0]            used_mask;
   logic [ROW_CELLS-1:0]            row_in;
   logic [ROW_CELLS-1:0]            lower_row;
   logic [ROW_CELLS-1:0]            next_row;
   logic                            accept;
   logic                            flush_go;
   logic                            push;
   llars_pkg::rsp_word_type         push_word;
   llars_pkg::fifo_status_type      fifo_status;

   // Row length register.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff <= llars_pkg::ROW_LENGTH_RESET;
      end else if (csr_wr_en) begin
         row_length_ff <= csr_wr_data;
      end
   end

   // Column j is in use when it lies below the row length.
   for (genvar j = 0; j < ROW_CELLS; j++) begin : g_mask
      assign used_mask[j] = row_length_ff > llars_pkg::LEN_WIDTH'(j);
   end

   // Handshake and the final flush cycle.
   assign req_ready = !flush_ff && fifo_status.has_space;
   assign accept    = req_valid && req_ready;
   assign flush_go  = flush_ff && fifo_status.has_space;
   assign row_in    = req_word.row_cells[ROW_CELLS-1:0] & used_mask;
   assign lower_row = flush_ff ? '0 : row_in;

   llars_lanes #(
      .ROW_CELLS (ROW_CELLS)
   ) u_lanes (
      .upper     (upper_ff),
      .middle    (middle_ff),
      .lower     (lower_row),
      .used_mask (used_mask),
      .next_row  (next_row)
   );

   // A word is produced for each row that completes a window, and on flush.
   assign push                 = flush_go || (accept && (held_ff != llars_pkg::HELD_NONE));
   assign push_word.next_cells = llars_pkg::CELLS_WIDTH'(next_row);
   assign push_word.final_row  = flush_ff;

   // Row window update.
   always_comb begin
      upper_in  = upper_ff;
      middle_in = middle_ff;
      held_in   = held_ff;
      flush_in  = flush_ff;
      if (flush_go) begin
         upper_in  = '0;
         middle_in = '0;
         held_in   = llars_pkg::HELD_NONE;
         flush_in  = 1'b0;
      end else if (accept) begin
         upper_in  = (held_ff == llars_pkg::HELD_NONE) ? '0 : middle_ff;
         middle_in = row_in;
         held_in   = (held_ff == llars_pkg::HELD_NONE) ? llars_pkg::HELD_ONE
                                                       : llars_pkg::HELD_TWO;
         flush_in  = req_word.last_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff  <= '0;
         middle_ff <= '0;
         held_ff   <= llars_pkg::HELD_NONE;
         flush_ff  <= 1'b0;
      end else begin
         upper_ff  <= upper_in;
         middle_ff <= middle_in;
         held_ff   <= held_in;
         flush_ff  <= flush_in;
      end
   end

   // Output buffer.
   llars_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .pop       (rsp_ready),
      .head_word (rsp_word),
      .status    (fifo_status)
   );

   assign rsp_valid = fifo_status.not_empty;

   // Checks on the row window control.
   `LLARS_ASSERT_NEXT(a_last_starts_flush, clock, reset, accept && req_word.last_row, flush_ff, "last row did not start a flush")
   `LLARS_ASSERT_NEXT(a_flush_clears, clock, reset, flush_go, !flush_ff && (held_ff == llars_pkg::HELD_NONE), "flush did not clear the row window")
   `LLARS_ASSERT_IMPLY(a_first_row_silent, clock, reset, accept && (held_ff == llars_pkg::HELD_NONE) && !req_word.last_row, !push, "first row produced a word")
   `LLARS_ASSERT_IMPLY(a_held_range, clock, reset, 1'b1, (held_ff == llars_pkg::HELD_NONE) || (held_ff == llars_pkg::HELD_ONE) || (held_ff == llars_pkg::HELD_TWO), "held row count out of range")

endmodule
`default_nettype wire
